>>> hdl/rfp_pkg.sv
`default_nettype none
package rfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hAA;
  localparam logic [7:0] END_BYTE    = 8'h8E;
  localparam logic [7:0] NOTICE_TYPE = 8'h02;
  localparam logic [7:0] NOTICE_CMD  = 8'h22;
  localparam logic [7:0] LEN_SLACK   = 8'd5;
  localparam int         EPC_BYTES   = 12;
  localparam int         COUNT_W     = 7;

  localparam logic [1:0] RK_FRAME = 2'd0;
  localparam logic [1:0] RK_ENTRY = 2'd1;
  localparam logic [1:0] RK_EMPTY = 2'd2;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_ADDED  = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_BADLEN = 3'd4;

  typedef struct packed {
    logic        good;
    logic [7:0]  ftype;
    logic [7:0]  cmd;
    logic [7:0]  plen;
    logic [7:0]  rssi;
    logic [7:0]  pc;
    logic [7:0]  elen;
    logic [95:0] epc;
  } frame_info_t;

  typedef struct packed {
    logic [95:0] epc;
    logic [3:0]  len;
    logic [7:0]  rssi;
    logic [7:0]  pc;
  } tag_entry_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_cmd;
    logic [7:0]  payload_len;
    logic [2:0]  tag_status;
    logic [3:0]  tag_index;
    logic [7:0]  rssi;
    logic [7:0]  pc_byte;
    logic [6:0]  epc_len;
    logic [31:0] epc_high;
    logic [63:0] epc_low;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/rfp_if.sv
`default_nettype none
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source (output valid, kind, rx_byte, input ready);
  modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_cmd;
  logic [7:0]  payload_len;
  logic [2:0]  tag_status;
  logic [3:0]  tag_index;
  logic [7:0]  rssi;
  logic [7:0]  pc_byte;
  logic [6:0]  epc_len;
  logic [31:0] epc_high;
  logic [63:0] epc_low;
  logic        last;
  modport source (output valid, result_kind, frame_type, frame_cmd, payload_len, tag_status,
                  tag_index, rssi, pc_byte, epc_len, epc_high, epc_low, last, input ready);
  modport sink (input valid, result_kind, frame_type, frame_cmd, payload_len, tag_status,
                tag_index, rssi, pc_byte, epc_len, epc_high, epc_low, last, output ready);
endinterface
`default_nettype wire

>>> hdl/rfp_frame_rx.sv
`default_nettype none
module rfp_frame_rx
  import rfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        strobe,
  input  wire logic [7:0]  rx_byte,
  output frame_info_t      info
);

  logic               in_frame;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] count_inc;
  logic [7:0]         running_sum;
  logic [7:0]         last_byte;
  logic               good;
  logic [7:0]         b0, b1, b3, b4, b5;
  logic [7:0]         epc_b [EPC_BYTES];
  logic               end_hit;
  logic               sum_ok;
  logic [7:0]         elen;

  assign count_inc = byte_count + 1'b1;
  assign end_hit = (rx_byte == END_BYTE) && (byte_count > COUNT_W'(3))
                   && ({2'b00, byte_count} >= ({1'b0, b3} + {1'b0, LEN_SLACK}));
  assign sum_ok = (8'(running_sum - last_byte) == last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
      good        <= 1'b0;
    end else begin
      good <= 1'b0;
      if (strobe) begin
        if (!in_frame) begin
          if (rx_byte == HDR_BYTE) begin
            in_frame    <= 1'b1;
            byte_count  <= '0;
            running_sum <= '0;
          end
        end else if (end_hit) begin
          good        <= sum_ok;
          in_frame    <= 1'b0;
          byte_count  <= '0;
          running_sum <= '0;
        end else if (count_inc >= COUNT_W'(MAX_FRAME_BYTES)) begin
          in_frame    <= 1'b0;
          byte_count  <= '0;
          running_sum <= '0;
        end else begin
          byte_count  <= count_inc;
          running_sum <= running_sum + rx_byte;
        end
      end
    end
  end

  // captured bytes at fixed frame positions
  always_ff @(posedge clk) begin
    if (strobe && in_frame && !end_hit) begin
      last_byte <= rx_byte;
      if (byte_count == COUNT_W'(0)) b0 <= rx_byte;
      if (byte_count == COUNT_W'(1)) b1 <= rx_byte;
      if (byte_count == COUNT_W'(3)) b3 <= rx_byte;
      if (byte_count == COUNT_W'(4)) b4 <= rx_byte;
      if (byte_count == COUNT_W'(5)) b5 <= rx_byte;
      for (int k = 0; k < EPC_BYTES; k++) begin
        if (byte_count == COUNT_W'(7 + k)) epc_b[k] <= rx_byte;
      end
    end
  end

  assign elen = (b3 > LEN_SLACK) ? 8'(b3 - LEN_SLACK) : 8'd0;

  always_comb begin
    info.good  = good;
    info.ftype = b0;
    info.cmd   = b1;
    info.plen  = b3;
    info.rssi  = b4;
    info.pc    = b5;
    info.elen  = elen;
    for (int k = 0; k < EPC_BYTES; k++) begin
      info.epc[95 - 8*k -: 8] = (8'(k) < elen) ? epc_b[k] : 8'd0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rfid_frame_parser_tag_dedup_unit.sv
`default_nettype none
// channel   dir  payload
// in_ch     in   kind, rx_byte
// out_ch    out  result_kind .. last, one word per result
//
// a received byte is checked in S_RXCHK; a good frame end emits a result, and a notice
// with a valid epc length compares each stored entry, then adds a new one if none matches
// a dump reads and emits each entry in turn; a dump of an empty table emits one empty word
// search and dump share one registered table read port; only the search uses the compare
// rst is synchronous; it empties the table and the frame parser
// in_ch is ready only while the sequencer is idle; out_ch stalls hold it
module rfid_frame_parser_tag_dedup_unit
  import rfp_pkg::*;
#(
  parameter int TABLE_ENTRIES   = 16,
  parameter int MAX_FRAME_BYTES = 100,
  parameter int MAX_EPC_BYTES   = 12
) (
  input wire logic  clk,
  input wire logic  rst,
  rfp_in_if.sink    in_ch,
  rfp_out_if.source out_ch
);

  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RXCHK  = 3'd1;
  localparam logic [2:0] S_SRD    = 3'd2;
  localparam logic [2:0] S_SCMP   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_DRD    = 3'd6;
  localparam logic [2:0] S_DEMIT  = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] tag_count;
  logic [CW-1:0] i;
  result_t       res;
  result_t       frame_res;
  result_t       out_res;
  logic          out_valid;
  logic          out_free;
  logic          accept;
  frame_info_t   info;
  tag_entry_t    mem [TABLE_ENTRIES];
  tag_entry_t    rd_data;
  logic          same;
  logic          is_notice;
  logic          elen_ok;
  logic [31:0]   i32;
  logic [31:0]   cnt32;
  logic          load;
  result_t       load_res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign i32   = 32'(i);
  assign cnt32 = 32'(tag_count);

  rfp_frame_rx #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_rx (
    .clk     (clk),
    .rst     (rst),
    .strobe  (accept && !in_ch.kind),
    .rx_byte (in_ch.rx_byte),
    .info    (info)
  );

  assign is_notice = (info.ftype == NOTICE_TYPE) && (info.cmd == NOTICE_CMD);
  assign elen_ok   = (info.elen >= 8'd1) && (info.elen <= 8'(MAX_EPC_BYTES));

  // prefix compare of the stored entry against the new epc
  always_comb begin
    same = ({4'd0, rd_data.len} <= info.elen);
    for (int k = 0; k < EPC_BYTES; k++) begin
      if ((4'(k) < rd_data.len) && (rd_data.epc[95 - 8*k -: 8] != info.epc[95 - 8*k -: 8]))
        same = 1'b0;
    end
  end

  // good frame word before the table decision
  always_comb begin
    frame_res = '0;
    frame_res.result_kind = RK_FRAME;
    frame_res.frame_type  = info.ftype;
    frame_res.frame_cmd   = info.cmd;
    frame_res.payload_len = info.plen;
    frame_res.last        = 1'b1;
    if (is_notice) begin
      frame_res.rssi     = info.rssi;
      frame_res.pc_byte  = info.pc;
      frame_res.epc_len  = info.elen[6:0];
      frame_res.epc_high = info.epc[95:64];
      frame_res.epc_low  = info.epc[63:0];
      if (!elen_ok) frame_res.tag_status = ST_BADLEN;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[i[IDXW-1:0]];
    if (state == S_DECIDE && tag_count < CW'(TABLE_ENTRIES)) begin
      mem[tag_count[IDXW-1:0]] <= '{epc: info.epc, len: info.elen[3:0],
                                    rssi: info.rssi, pc: info.pc};
    end
  end

  always_comb begin
    load     = 1'b0;
    load_res = res;
    if (state == S_EMIT && out_free) begin
      load = 1'b1;
    end else if (state == S_DEMIT && out_free) begin
      load = 1'b1;
      load_res = '0;
      load_res.result_kind = RK_ENTRY;
      load_res.tag_index   = i32[3:0];
      load_res.rssi        = rd_data.rssi;
      load_res.pc_byte     = rd_data.pc;
      load_res.epc_len     = {3'd0, rd_data.len};
      load_res.epc_high    = rd_data.epc[95:64];
      load_res.epc_low     = rd_data.epc[63:0];
      load_res.last        = (i + 1'b1 == tag_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tag_count <= '0;
      i         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          i <= '0;
          if (accept) begin
            if (!in_ch.kind) begin
              state <= S_RXCHK;
            end else if (tag_count == '0) begin
              res <= '{result_kind: RK_EMPTY, last: 1'b1, default: '0};
              state <= S_EMIT;
            end else begin
              state <= S_DRD;
            end
          end
        end
        S_RXCHK: begin
          if (!info.good) begin
            state <= S_IDLE;
          end else begin
            res <= frame_res;
            if (is_notice && elen_ok) begin
              if (tag_count == '0) begin
                state <= S_DECIDE;
              end else begin
                state <= S_SRD;
              end
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (same) begin
            res.tag_status <= ST_DUP;
            res.tag_index  <= i32[3:0];
            state <= S_EMIT;
          end else if (i + 1'b1 == tag_count) begin
            state <= S_DECIDE;
          end else begin
            i <= i + 1'b1;
            state <= S_SRD;
          end
        end
        S_DECIDE: begin
          if (tag_count < CW'(TABLE_ENTRIES)) begin
            res.tag_status <= ST_ADDED;
            res.tag_index  <= cnt32[3:0];
            tag_count <= tag_count + 1'b1;
          end else begin
            res.tag_status <= ST_FULL;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        S_DRD: state <= S_DEMIT;
        S_DEMIT: begin
          if (out_free) begin
            if (i + 1'b1 == tag_count) begin
              tag_count <= '0;
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
              state <= S_DRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= load_res;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = out_res.result_kind;
  assign out_ch.frame_type  = out_res.frame_type;
  assign out_ch.frame_cmd   = out_res.frame_cmd;
  assign out_ch.payload_len = out_res.payload_len;
  assign out_ch.tag_status  = out_res.tag_status;
  assign out_ch.tag_index   = out_res.tag_index;
  assign out_ch.rssi        = out_res.rssi;
  assign out_ch.pc_byte     = out_res.pc_byte;
  assign out_ch.epc_len     = out_res.epc_len;
  assign out_ch.epc_high    = out_res.epc_high;
  assign out_ch.epc_low     = out_res.epc_low;
  assign out_ch.last        = out_res.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tag_count <= CW'(TABLE_ENTRIES)) else $error("tag count beyond table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCMP || state == S_DEMIT) |-> (i < tag_count))
    else $error("table scan past last entry");

  a_dump_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEMIT && out_free && i + 1'b1 == tag_count) |=> (tag_count == '0))
    else $error("dump did not empty table");

endmodule
`default_nettype wire
